### rtl/lsvq_pkg.sv
// shared constants and types for the line sensor vote qualifier
package lsvq_pkg;

    localparam int MAIN_SENSORS     = 24;
    localparam int SIDE_SENSORS     = 3;
    localparam int TOTAL_SENSORS    = MAIN_SENSORS + SIDE_SENSORS;
    localparam int SAMPLE_BITS      = 12;
    localparam int SAMPLE_FIELD     = 12;
    localparam int SENSOR_BITS      = 5;
    localparam int CFG_BITS         = 12;
    localparam int CFG_INDEX_BITS   = 1;
    localparam int HIT_BITS         = 2;
    localparam int HIT_LIMIT        = 3;
    localparam int MAIN_HITS_NEEDED = 2;
    localparam int SIDE_HITS_NEEDED = 1;
    localparam int STABLE_LIMIT     = 50;
    localparam int STABLE_BITS      = 6;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_MAIN_THRESHOLD = 1'b0,
        REG_SIDE_THRESHOLD = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [SENSOR_BITS-1:0]  sensor;
        logic [SAMPLE_FIELD-1:0] sample;
        logic                    end_of_scan;
    } sample_t;

    typedef struct packed {
        logic [MAIN_SENSORS-1:0] main_lines;
        logic [SIDE_SENSORS-1:0] side_lines;
        logic [STABLE_BITS-1:0]  stable_count;
    } status_t;

    typedef struct packed {
        logic                   valid;
        logic [SENSOR_BITS-1:0] sensor;
        logic                   hit;
        logic                   last;
    } stage_t;

endpackage

### rtl/lsvq_ingress.sv
// threshold registers, hit decision and input stage register
module lsvq_ingress (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [lsvq_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [lsvq_pkg::CFG_BITS-1:0]       cfg_data,
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  lsvq_pkg::sample_t                   sample_data,
    input  logic                                result_free,
    output lsvq_pkg::stage_t                    stage,
    output logic                                stage_go
);
    import lsvq_pkg::*;

    logic [CFG_BITS-1:0]    main_th_reg;
    logic [CFG_BITS-1:0]    main_th_next;
    logic [CFG_BITS-1:0]    side_th_reg;
    logic [CFG_BITS-1:0]    side_th_next;
    stage_t                 stage_reg;
    stage_t                 stage_next;
    logic [CFG_BITS-1:0]    threshold;
    logic                   in_range;
    logic                   load;

    always_comb
    begin
        main_th_next = main_th_reg;
        side_th_next = side_th_reg;
        if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MAIN_THRESHOLD: main_th_next = cfg_data;
                REG_SIDE_THRESHOLD: side_th_next = cfg_data;
            endcase
        end
    end

    // an end-of-scan item waits until the result register is free
    assign stage_go     = stage_reg.valid && (!stage_reg.last || result_free);
    assign sample_stall = stage_reg.valid && !stage_go;
    assign load         = sample_valid && !sample_stall;

    assign in_range  = sample_data.sensor < SENSOR_BITS'(TOTAL_SENSORS);
    assign threshold = (sample_data.sensor < SENSOR_BITS'(MAIN_SENSORS)) ? main_th_reg
                                                                         : side_th_reg;

    always_comb
    begin
        stage_next = stage_reg;
        if (load)
        begin
            stage_next.valid  = 1'b1;
            stage_next.sensor = sample_data.sensor;
            stage_next.hit    = in_range && (sample_data.sample[SAMPLE_BITS-1:0] >
                                             threshold[SAMPLE_BITS-1:0]);
            stage_next.last   = sample_data.end_of_scan;
        end
        else if (stage_go)
        begin
            stage_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_th_reg <= '0;
            side_th_reg <= '0;
            stage_reg   <= '0;
        end
        else
        begin
            main_th_reg <= main_th_next;
            side_th_reg <= side_th_next;
            stage_reg   <= stage_next;
        end
    end

    assign stage = stage_reg;

endmodule

### rtl/lsvq_tally.sv
// hit counters, status vote, stable count and result register
module lsvq_tally (
    input  logic              clk,
    input  logic              rst_n,
    input  lsvq_pkg::stage_t  stage,
    input  logic              stage_go,
    output logic              result_free,
    output logic              status_valid,
    input  logic              status_stall,
    output lsvq_pkg::status_t status_data
);
    import lsvq_pkg::*;

    logic [HIT_BITS-1:0]     counts_reg  [TOTAL_SENSORS];
    logic [HIT_BITS-1:0]     counts_next [TOTAL_SENSORS];
    logic [HIT_BITS-1:0]     counts_after[TOTAL_SENSORS];
    logic [MAIN_SENSORS-1:0] prev_main_reg;
    logic [SIDE_SENSORS-1:0] prev_side_reg;
    logic [STABLE_BITS-1:0]  stable_reg;
    logic [STABLE_BITS-1:0]  stable_next;
    logic [MAIN_SENSORS-1:0] main_vote;
    logic [SIDE_SENSORS-1:0] side_vote;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    status_t                 out_data_reg;
    logic                    close;

    assign close       = stage_go && stage.last;
    assign result_free = !out_valid_reg || !status_stall;

    always_comb
    begin
        for (int i = 0; i < TOTAL_SENSORS; i++)
        begin
            counts_after[i] = counts_reg[i];
            if (stage_go && stage.hit && stage.sensor == SENSOR_BITS'(i)
                && counts_reg[i] != HIT_BITS'(HIT_LIMIT))
            begin
                counts_after[i] = counts_reg[i] + HIT_BITS'(1);
            end
            counts_next[i] = close ? '0 : counts_after[i];
        end
        for (int i = 0; i < MAIN_SENSORS; i++)
        begin
            main_vote[i] = counts_after[i] >= HIT_BITS'(MAIN_HITS_NEEDED);
        end
        for (int i = 0; i < SIDE_SENSORS; i++)
        begin
            side_vote[i] = counts_after[MAIN_SENSORS + i] >= HIT_BITS'(SIDE_HITS_NEEDED);
        end
    end

    always_comb
    begin
        if (main_vote == prev_main_reg && side_vote == prev_side_reg)
        begin
            stable_next = (stable_reg < STABLE_BITS'(STABLE_LIMIT))
                        ? stable_reg + STABLE_BITS'(1) : stable_reg;
        end
        else
        begin
            stable_next = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (close)
        begin
            out_valid_next = 1'b1;
        end
        else if (!status_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TOTAL_SENSORS; i++)
            begin
                counts_reg[i] <= '0;
            end
            prev_main_reg <= '0;
            prev_side_reg <= '0;
            stable_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            counts_reg    <= counts_next;
            out_valid_reg <= out_valid_next;
            if (close)
            begin
                prev_main_reg <= main_vote;
                prev_side_reg <= side_vote;
                stable_reg    <= stable_next;
            end
        end
    end

    // result payload, loaded on transfer of an end-of-scan item
    always_ff @(posedge clk)
    begin
        if (close)
        begin
            out_data_reg.main_lines   <= main_vote;
            out_data_reg.side_lines   <= side_vote;
            out_data_reg.stable_count <= stable_next;
        end
    end

    assign status_valid = out_valid_reg;
    assign status_data  = out_data_reg;

endmodule

### rtl/line_sensor_vote_qualifier.sv
// top level of the line sensor vote qualifier
//
// sample channel: sample_valid / sample_stall / sample_data carries one converter
// reading with its logical sensor index and an end-of-scan flag; a transfer
// happens on a rising edge with sample_valid high and sample_stall low.
// status channel: status_valid / status_stall / status_data carries one result
// per end-of-scan sample: main and side line vectors and the stable count.
// cfg port: cfg_write with cfg_index and cfg_data sets the main or side
// threshold; write it only while no scan is in flight.
// throughput: one sample per clock while sample_stall is low. a sample is registered
// in the input stage register and counted from there; an end-of-scan result is loaded
// into the output register as its sample leaves the input stage register.
// the output register frees the input side: samples keep flowing while a
// result waits; only an end-of-scan sample that meets a still-stalled result
// holds sample_stall high until the result is taken.
// reset clears thresholds, hit counters, previous statuses and stable count.
module line_sensor_vote_qualifier (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [lsvq_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [lsvq_pkg::CFG_BITS-1:0]       cfg_data,
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  lsvq_pkg::sample_t                   sample_data,
    output logic                                status_valid,
    input  logic                                status_stall,
    output lsvq_pkg::status_t                   status_data
);
    import lsvq_pkg::*;

    stage_t stage;
    logic   stage_go;
    logic   result_free;

    lsvq_ingress u_ingress (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_data  (sample_data),
        .result_free  (result_free),
        .stage        (stage),
        .stage_go     (stage_go)
    );

    lsvq_tally u_tally (
        .clk          (clk),
        .rst_n        (rst_n),
        .stage        (stage),
        .stage_go     (stage_go),
        .result_free  (result_free),
        .status_valid (status_valid),
        .status_stall (status_stall),
        .status_data  (status_data)
    );

endmodule

### rtl/lsvq_checker.sv
// port checker for the line sensor vote qualifier and its bind
module lsvq_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              sample_stall,
    input logic              status_valid,
    input logic              status_stall,
    input lsvq_pkg::status_t status_data
);
    import lsvq_pkg::*;

    // held result stays put
    a_status_hold: assert property (@(posedge clk) disable iff (!rst_n)
        status_valid && status_stall |=> status_valid && $stable(status_data))
        else $error("status changed while stalled");

    // input back-pressure only comes from a blocked result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> status_valid && status_stall)
        else $error("sample stall without pending result");

    a_stable_bound: assert property (@(posedge clk) disable iff (!rst_n)
        status_valid |-> status_data.stable_count <= STABLE_BITS'(STABLE_LIMIT))
        else $error("stable count above limit");

    // nothing pending right after reset
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !status_valid && !sample_stall)
        else $error("busy after reset");

endmodule

bind line_sensor_vote_qualifier lsvq_checker u_checker (.*);

### test/lsvq_checker.sv
// scoreboard for the line sensor vote qualifier: predicts and compares status results
module lsvq_scoreboard (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [lsvq_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [lsvq_pkg::CFG_BITS-1:0]       cfg_data,
    input  logic                                sample_valid,
    input  logic                                sample_stall,
    input  lsvq_pkg::sample_t                   sample_data,
    input  logic                                status_valid,
    input  logic                                status_stall,
    input  lsvq_pkg::status_t                   status_data,
    output int                                  errors,
    output int                                  pending,
    output int                                  checked,
    output int                                  peak_run
);
    timeunit 1ns;
    timeprecision 1ps;
    import lsvq_pkg::*;

    logic [HIT_BITS-1:0]     hit_count [TOTAL_SENSORS];
    logic [MAIN_SENSORS-1:0] prev_main;
    logic [SIDE_SENSORS-1:0] prev_side;
    logic [STABLE_BITS-1:0]  run_len;
    logic [CFG_BITS-1:0]     main_level;
    logic [CFG_BITS-1:0]     side_level;
    status_t                 status_due [$];
    int                      mismatch_count;
    int                      match_count;
    int                      run_peak;

    task automatic tally_sample(input sample_t s);
        logic [CFG_BITS-1:0] level;
        status_t             st;
        if (s.sensor < TOTAL_SENSORS) begin
            level = (s.sensor < MAIN_SENSORS) ? main_level : side_level;
            if (s.sample > level && hit_count[s.sensor] < HIT_LIMIT)
                hit_count[s.sensor] = hit_count[s.sensor] + 1'b1;
        end
        if (s.end_of_scan) begin
            for (int i = 0; i < MAIN_SENSORS; i++)
                st.main_lines[i] = (hit_count[i] >= MAIN_HITS_NEEDED);
            for (int i = 0; i < SIDE_SENSORS; i++)
                st.side_lines[i] = (hit_count[MAIN_SENSORS + i] >= SIDE_HITS_NEEDED);
            if (st.main_lines == prev_main && st.side_lines == prev_side) begin
                if (run_len < STABLE_LIMIT)
                    run_len = run_len + 1'b1;
            end
            else begin
                run_len = '0;
            end
            st.stable_count = run_len;
            if (run_len > run_peak)
                run_peak = run_len;
            prev_main = st.main_lines;
            prev_side = st.side_lines;
            for (int i = 0; i < TOTAL_SENSORS; i++)
                hit_count[i] = '0;
            status_due.push_back(st);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        status_t want;
        if (!rst_n) begin
            for (int i = 0; i < TOTAL_SENSORS; i++)
                hit_count[i] = '0;
            prev_main      = '0;
            prev_side      = '0;
            run_len        = '0;
            main_level     = '0;
            side_level     = '0;
            status_due.delete();
            mismatch_count = 0;
            match_count    = 0;
            run_peak       = 0;
        end
        else begin
            if (cfg_write) begin
                if (cfg_index == REG_MAIN_THRESHOLD)
                    main_level = cfg_data;
                else if (cfg_index == REG_SIDE_THRESHOLD)
                    side_level = cfg_data;
            end
            if (status_valid && !status_stall) begin
                if (status_due.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("%0t: status transfer with none expected: %s",
                                 $realtime,
                                 $sformatf("main=%h side=%h count=%0d",
                                           status_data.main_lines, status_data.side_lines,
                                           status_data.stable_count));
                    mismatch_count++;
                end
                else begin
                    want = status_due.pop_front();
                    match_count++;
                    if (status_data.main_lines != want.main_lines
                        || status_data.side_lines != want.side_lines
                        || status_data.stable_count != want.stable_count) begin
                        if (mismatch_count < 10)
                            $display("%0t: status mismatch: expected %s, got %s",
                                     $realtime,
                                     $sformatf("main=%h side=%h count=%0d",
                                               want.main_lines, want.side_lines,
                                               want.stable_count),
                                     $sformatf("main=%h side=%h count=%0d",
                                               status_data.main_lines,
                                               status_data.side_lines,
                                               status_data.stable_count));
                        mismatch_count++;
                    end
                end
            end
            if (sample_valid && !sample_stall)
                tally_sample(sample_data);
        end
        errors   <= mismatch_count;
        pending  <= status_due.size();
        checked  <= match_count;
        peak_run <= run_peak;
    end

endmodule

### test/tb_top.sv
// testbench top for the line sensor vote qualifier: clock, reset, stimulus and verdict
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lsvq_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 90;
    localparam int SETTLE       = 6;
    localparam int PHASE_ITEMS  = 210;
    localparam int PHASES       = 8;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_write = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = REG_MAIN_THRESHOLD;
    logic [CFG_BITS-1:0]       cfg_data = '0;
    logic                      sample_valid = 1'b0;
    logic                      sample_stall;
    sample_t                   sample_data = '0;
    logic                      status_valid;
    logic                      status_stall = 1'b0;
    status_t                   status_data;

    int                        fail_count;
    int                        pending;
    int                        checked;
    int                        peak_run;
    int                        cycle_count = 0;
    int                        sent = 0;
    int                        settings = 0;
    int                        steady = 0;
    bit                        calm = 1'b0;
    bit                        hold_req = 1'b0;
    bit                        hold_busy = 1'b0;
    logic [CFG_BITS-1:0]       main_level = '0;
    logic [CFG_BITS-1:0]       side_level = '0;
    logic [MAIN_SENSORS-1:0]   scene_main;
    logic [SIDE_SENSORS-1:0]   scene_side;

    line_sensor_vote_qualifier u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_data  (sample_data),
        .status_valid (status_valid),
        .status_stall (status_stall),
        .status_data  (status_data)
    );

    lsvq_scoreboard u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_data  (sample_data),
        .status_valid (status_valid),
        .status_stall (status_stall),
        .status_data  (status_data),
        .errors       (fail_count),
        .pending      (pending),
        .checked      (checked),
        .peak_run     (peak_run)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    // status side back-pressure: random bursts, quiet stretches, one long hold-off
    initial
    begin
        int pick;
        @(posedge clk);
        forever begin
            if (hold_req) begin
                hold_busy = 1'b1;
                status_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req  = 1'b0;
                hold_busy = 1'b0;
            end
            else if (calm) begin
                status_stall <= 1'b0;
                @(posedge clk);
            end
            else begin
                pick = $urandom_range(0, 9);
                if (pick < 3) begin
                    status_stall <= 1'b1;
                    repeat ($urandom_range(1, 9)) @(posedge clk);
                end
                else if (pick == 9) begin
                    status_stall <= 1'b0;
                    repeat ($urandom_range(30, 80)) @(posedge clk);
                end
                else begin
                    status_stall <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge clk);
                end
            end
        end
    end

    function automatic sample_t make_sample(input int sensor, input int level, input bit last);
        sample_t s;
        s.sensor      = SENSOR_BITS'(sensor);
        s.sample      = SAMPLE_FIELD'(level);
        s.end_of_scan = last;
        return s;
    endfunction

    function automatic int over_level(input logic [CFG_BITS-1:0] level);
        if (level == '1)
            return int'(level);
        if ($urandom_range(0, 3) == 0)
            return int'(level) + 1;
        return $urandom_range(int'(level) + 1, 4095);
    endfunction

    function automatic int under_level(input logic [CFG_BITS-1:0] level);
        if ($urandom_range(0, 3) == 0)
            return int'(level);
        return $urandom_range(0, int'(level));
    endfunction

    function automatic int pick_level();
        int pick;
        pick = $urandom_range(0, 5);
        if (pick == 0)
            return 0;
        if (pick == 1)
            return 4095;
        return $urandom_range(0, 4095);
    endfunction

    task automatic send(input sample_t s);
        if (!calm) begin
            if (steady > 0)
                steady--;
            else if ($urandom_range(0, 19) == 0)
                steady = 40;
            else if ($urandom_range(0, 3) == 0) begin
                sample_valid <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
        end
        sample_valid <= 1'b1;
        sample_data  <= s;
        do
            @(posedge clk);
        while (sample_stall);
        sent++;
    endtask

    // sender pause until every status result has come back
    task automatic drain();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_thresholds(input int main_lvl, input int side_lvl);
        cfg_write  <= 1'b1;
        cfg_index  <= REG_MAIN_THRESHOLD;
        cfg_data   <= CFG_BITS'(main_lvl);
        @(posedge clk);
        cfg_index  <= REG_SIDE_THRESHOLD;
        cfg_data   <= CFG_BITS'(side_lvl);
        @(posedge clk);
        cfg_write  <= 1'b0;
        main_level = CFG_BITS'(main_lvl);
        side_level = CFG_BITS'(side_lvl);
        settings++;
    endtask

    task automatic pick_scene();
        scene_main = '0;
        repeat ($urandom_range(0, 5))
            scene_main[$urandom_range(0, MAIN_SENSORS - 1)] = 1'b1;
        if ($urandom_range(0, 11) == 0)
            scene_main = '1;
        scene_side = SIDE_SENSORS'($urandom_range(0, 7));
    endtask

    // one scan: well-formed around the current scene, or random noise
    task automatic send_scan(input bit noisy);
        sample_t scan_q [$];
        sample_t tmp;
        int      j;
        int      k;
        if (noisy) begin
            repeat ($urandom_range(1, 30))
                scan_q.push_back(make_sample($urandom_range(0, 31),
                                             $urandom_range(0, 4095), 1'b0));
        end
        else begin
            for (int i = 0; i < MAIN_SENSORS; i++)
                if (scene_main[i])
                    repeat ($urandom_range(2, 4))
                        scan_q.push_back(make_sample(i, over_level(main_level), 1'b0));
            for (int i = 0; i < SIDE_SENSORS; i++)
                if (scene_side[i])
                    repeat ($urandom_range(1, 2))
                        scan_q.push_back(make_sample(MAIN_SENSORS + i,
                                                     over_level(side_level), 1'b0));
            repeat ($urandom_range(0, 6)) begin
                j = $urandom_range(0, TOTAL_SENSORS - 1);
                if (j < MAIN_SENSORS && !scene_main[j])
                    scan_q.push_back(make_sample(j, under_level(main_level), 1'b0));
                else if (j >= MAIN_SENSORS && !scene_side[j - MAIN_SENSORS])
                    scan_q.push_back(make_sample(j, under_level(side_level), 1'b0));
            end
            // a lone hit on an unlit main sensor must not light it
            j = $urandom_range(0, MAIN_SENSORS - 1);
            if ($urandom_range(0, 2) == 0 && !scene_main[j])
                scan_q.push_back(make_sample(j, over_level(main_level), 1'b0));
            if ($urandom_range(0, 4) == 0)
                scan_q.push_back(make_sample($urandom_range(TOTAL_SENSORS, 31),
                                             $urandom_range(0, 4095), 1'b0));
        end
        if (scan_q.size() == 0)
            scan_q.push_back(make_sample($urandom_range(TOTAL_SENSORS, 31),
                                         $urandom_range(0, 4095), 1'b0));
        for (int i = scan_q.size() - 1; i > 0; i--) begin
            k         = $urandom_range(0, i);
            tmp       = scan_q[i];
            scan_q[i] = scan_q[k];
            scan_q[k] = tmp;
        end
        scan_q[scan_q.size() - 1].end_of_scan = 1'b1;
        foreach (scan_q[i])
            send(scan_q[i]);
    endtask

    initial
    begin
        int phase_start;
        int scene_left;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first scan after reset, all clear against the reset thresholds
        send(make_sample(0, 0, 1'b1));
        drain();

        set_thresholds(2000, 100);
        send(make_sample(0, 4095, 1'b0));
        send(make_sample(0, 4095, 1'b0));
        repeat (4) send(make_sample(23, 2001, 1'b0));
        send(make_sample(5, 2000, 1'b0));
        send(make_sample(5, 2000, 1'b0));
        send(make_sample(7, 2001, 1'b0));
        send(make_sample(24, 101, 1'b0));
        send(make_sample(25, 100, 1'b0));
        send(make_sample(26, 4095, 1'b0));
        send(make_sample(27, 4095, 1'b0));
        send(make_sample(31, 4095, 1'b1));
        send(make_sample(0, 0, 1'b1));
        send(make_sample(31, 0, 1'b1));
        drain();

        set_thresholds(4095, 4095);
        send(make_sample(12, 4095, 1'b0));
        send(make_sample(12, 4095, 1'b0));
        send(make_sample(26, 4095, 1'b1));
        drain();

        set_thresholds(0, 0);
        send(make_sample(12, 1, 1'b0));
        send(make_sample(12, 1, 1'b0));
        send(make_sample(25, 1, 1'b1));

        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            case (phase)
                3:       set_thresholds(0, 4095);
                4:       set_thresholds(4095, 0);
                default: set_thresholds(pick_level(), pick_level());
            endcase
            if (phase == PHASES - 1)
                calm = 1'b1;
            phase_start = sent;
            // run of identical empty scans to reach the stable count ceiling
            if (phase == 1)
                repeat (STABLE_LIMIT + 5)
                    send(make_sample($urandom_range(0, MAIN_SENSORS - 1),
                                     under_level(main_level), 1'b1));
            // long result hold-off while the sender keeps offering scans
            if (phase == 2) begin
                drain();
                hold_req = 1'b1;
                while (!hold_busy)
                    @(posedge clk);
                repeat (12)
                    send(make_sample($urandom_range(0, 31), $urandom_range(0, 4095), 1'b1));
            end
            scene_left = 0;
            while (sent - phase_start < PHASE_ITEMS) begin
                if (scene_left == 0) begin
                    pick_scene();
                    scene_left = $urandom_range(1, 8);
                end
                scene_left--;
                send_scan($urandom_range(0, 4) == 0);
            end
        end

        drain();
        $display("covered %0d samples and %0d checked status transfers",
                 sent, checked);
        $display("over %0d threshold settings; stable count peaked at %0d",
                 settings, peak_run);
        if (pending != 0)
            $display("%0d expected status results never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
